// ===== rtl/core/h264ns_pkg.sv =====
// Package: shared types and constants of the Annex B NAL unit splitter.
`timescale 1ns / 1ps

package h264ns_pkg;

    // Widths of the reported fields
    localparam int OUT_BITS    = 32;
    localparam int LIMIT_BITS  = 16;
    localparam int BYTE_BITS   = 8;

    // Result queue depth and pointer widths
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // Stream constants
    localparam logic [BYTE_BITS-1:0]  START_BYTE    = 8'h01;
    localparam logic [BYTE_BITS-1:0]  ZERO_BYTE     = 8'h00;
    localparam logic [1:0]            ZRUN_MAX      = 2'd2;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET   = 16'd4096;
    localparam logic [LIMIT_BITS-1:0] SEEN_MAX      = 16'hFFFF;

    // Result kinds
    localparam logic KIND_UNIT  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef enum logic [1:0] {
        PH_OPENING = 2'd0,
        PH_BODY    = 2'd1,
        PH_SKIP    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_NO_UNIT     = 3'd1,
        ERR_BAD_OPENING = 3'd2,
        ERR_EMPTY_UNIT  = 3'd3,
        ERR_FORBIDDEN   = 3'd4,
        ERR_TOO_MANY    = 3'd5
    } err_code_t;

    // Input transaction
    typedef struct packed {
        logic [BYTE_BITS-1:0] byte_value;
        logic                 stream_last;
    } in_t;

    // Output transaction
    typedef struct packed {
        logic                kind;
        logic [OUT_BITS-1:0] unit_offset;
        logic [OUT_BITS-1:0] unit_length;
        logic [4:0]          unit_type;
        logic [1:0]          ref_idc;
        err_code_t           error_code;
        logic                stream_done;
        logic                last_in_run;
    } out_t;

    // Results produced by one byte, handed to the result queue
    typedef struct packed {
        logic [1:0] count;
        out_t       first;
        out_t       second;
    } res_push_t;

endpackage

// ===== rtl/core/h264ns_result_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
`timescale 1ns / 1ps

module h264ns_result_fifo
    import h264ns_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_push_t push,
    output logic      room_for_two,
    output logic      out_valid,
    input  logic      out_ready,
    output out_t      out_data
);

    out_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wptr_reg;
    logic [FIFO_PTR_W-1:0] wptr_next;
    logic [FIFO_PTR_W-1:0] wptr_plus1;
    logic [FIFO_PTR_W-1:0] rptr_reg;
    logic [FIFO_PTR_W-1:0] rptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  pop;

    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_data     = mem_reg[rptr_reg];
    assign room_for_two = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign wptr_plus1   = wptr_reg + 1'b1;

    // Pointer and fill count
    always_comb
    begin
        wptr_next  = wptr_reg + FIFO_PTR_W'(push.count);
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wptr_plus1] <= push.second;
        end
    end

    // Fill count never exceeds the depth
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // A push of two only happens when two slots were free
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2))
        else $error("double push without room");

endmodule

// ===== rtl/core/h264_annex_b_nal_splitter_top.sv =====
// Top level: Annex B byte stream splitter reporting NAL unit descriptors and errors.
//
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------
// in       | input     | in_valid/in_ready  | in_t: byte_value, stream_last
// out      | output    | out_valid/out_ready| out_t: descriptor or error
// cfg      | input     | cfg_write_enable   | cfg_write_data: unit_limit
//
// One byte is taken per cycle while in_ready is high; its results enter a
// 4-entry result queue the same cycle and can appear at out in the next cycle.
// A start code on the final byte that closes a unit cleanly yields a descriptor
// and an empty-unit error; the queue drains one result per cycle while out_ready
// is high; in_ready is high while two queue slots are free, independent of out_ready.
// Reset restores the opening state and a unit limit of 4096.
`timescale 1ns / 1ps

module h264_annex_b_nal_splitter_top
    import h264ns_pkg::*;
#(
    parameter int POSITION_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_data,
    input  logic                  cfg_write_enable,
    input  logic [LIMIT_BITS-1:0] cfg_write_data
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // Stream state
    phase_t                   phase_reg,  phase_next;
    logic [POSITION_BITS-1:0] pos_reg,    pos_next;
    logic [1:0]               zrun_reg,   zrun_next;
    logic [POSITION_BITS-1:0] start_reg,  start_next;
    logic [POSITION_BITS-1:0] stop_reg,   stop_next;
    logic [BYTE_BITS-1:0]     hdr_reg,    hdr_next;
    logic [LIMIT_BITS-1:0]    seen_reg,   seen_next;
    logic [LIMIT_BITS-1:0]    limit_reg;

    logic                     accept;
    logic [BYTE_BITS-1:0]     b;
    logic                     last;
    logic [POSITION_BITS-1:0] p_inc;
    logic [BYTE_BITS-1:0]     hdr_eff;
    logic                     is_sc;
    logic [POSITION_BITS-1:0] close_stop;
    logic                     close_fail;
    err_code_t                close_code;
    logic                     stop_err;
    res_push_t                push;

    // Clamp a position to the 32-bit output range
    function automatic logic [OUT_BITS-1:0] sat32(input logic [POSITION_BITS-1:0] v);
        logic [POSITION_BITS-1:0] hi;
        hi = v >> OUT_BITS;
        return (hi != '0) ? '1 : OUT_BITS'(v);
    endfunction

    function automatic out_t make_err(input logic [OUT_BITS-1:0] off, input err_code_t code);
        out_t r;
        r             = '0;
        r.kind        = KIND_ERROR;
        r.unit_offset = off;
        r.error_code  = code;
        r.stream_done = 1'b1;
        return r;
    endfunction

    assign accept = in_valid && in_ready;
    assign b      = in_data.byte_value;
    assign last   = in_data.stream_last;

    // Shared per-byte terms
    assign p_inc      = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign hdr_eff    = (pos_reg == start_reg) ? b : hdr_reg;
    assign is_sc      = (b == START_BYTE) && zrun_reg[1];
    assign close_stop = (is_sc || b == ZERO_BYTE) ? stop_reg : p_inc;

    // Unit close checks in priority order: empty, forbidden bit, limit
    always_comb
    begin
        close_fail = 1'b1;
        if (close_stop <= start_reg)
            close_code = ERR_EMPTY_UNIT;
        else if (hdr_eff[7])
            close_code = ERR_FORBIDDEN;
        else if (seen_reg >= limit_reg)
            close_code = ERR_TOO_MANY;
        else
        begin
            close_code = ERR_NONE;
            close_fail = 1'b0;
        end
    end

    // Next state and results for one byte
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = p_inc;
        zrun_next   = zrun_reg;
        start_next  = start_reg;
        stop_next   = stop_reg;
        hdr_next    = hdr_reg;
        seen_next   = seen_reg;
        stop_err    = 1'b0;
        push        = '0;

        // Descriptor for the unit being closed
        push.first.kind        = KIND_UNIT;
        push.first.unit_offset = sat32(start_reg);
        push.first.unit_length = sat32(close_stop - start_reg);
        push.first.unit_type   = hdr_eff[4:0];
        push.first.ref_idc     = hdr_eff[6:5];
        push.first.error_code  = ERR_NONE;
        push.first.stream_done = 1'b0;
        push.first.last_in_run = 1'b0;

        case (phase_reg)
            PH_SKIP:
            begin
                // drop bytes until the stream ends
            end
            PH_BODY:
            begin
                if (pos_reg == start_reg)
                    hdr_next = b;
                if (is_sc)
                begin
                    if (close_fail)
                    begin
                        push.first = make_err(sat32(start_reg), close_code);
                        push.count = 2'd1;
                        stop_err   = 1'b1;
                    end
                    else
                    begin
                        push.count = 2'd1;
                        if (seen_reg != SEEN_MAX)
                            seen_next = seen_reg + 1'b1;
                        start_next = p_inc;
                        stop_next  = p_inc;
                        zrun_next  = '0;
                        if (last)
                        begin
                            push.second = make_err(sat32(p_inc), ERR_EMPTY_UNIT);
                            push.count  = 2'd2;
                            stop_err    = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (b == ZERO_BYTE)
                    begin
                        if (zrun_reg < ZRUN_MAX)
                            zrun_next = zrun_reg + 1'b1;
                    end
                    else
                    begin
                        zrun_next = '0;
                        stop_next = p_inc;
                    end
                    if (last)
                    begin
                        push.count = 2'd1;
                        if (close_fail)
                        begin
                            push.first = make_err(sat32(start_reg), close_code);
                            stop_err   = 1'b1;
                        end
                        else
                        begin
                            push.first.stream_done = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                // opening: at least two zeros, then 01
                if (b == ZERO_BYTE)
                begin
                    if (zrun_reg < ZRUN_MAX)
                        zrun_next = zrun_reg + 1'b1;
                    if (last)
                    begin
                        push.first = make_err('0, ERR_NO_UNIT);
                        push.count = 2'd1;
                        stop_err   = 1'b1;
                    end
                end
                else if (!zrun_reg[1] || b != START_BYTE)
                begin
                    push.first = make_err(sat32(pos_reg), ERR_BAD_OPENING);
                    push.count = 2'd1;
                    stop_err   = 1'b1;
                end
                else
                begin
                    start_next = p_inc;
                    stop_next  = p_inc;
                    zrun_next  = '0;
                    phase_next = PH_BODY;
                    if (last)
                    begin
                        push.first = make_err(sat32(p_inc), ERR_EMPTY_UNIT);
                        push.count = 2'd1;
                        stop_err   = 1'b1;
                    end
                end
            end
        endcase

        // Mark the final result of this byte
        if (push.count == 2'd1)
            push.first.last_in_run = 1'b1;
        if (push.count == 2'd2)
            push.second.last_in_run = 1'b1;

        if (stop_err)
            phase_next = PH_SKIP;

        // End of stream returns everything to the opening
        if (last)
        begin
            phase_next = PH_OPENING;
            pos_next   = '0;
            zrun_next  = '0;
            start_next = '0;
            stop_next  = '0;
            hdr_next   = '0;
            seen_next  = '0;
        end

        if (!accept)
            push.count = 2'd0;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OPENING;
            pos_reg   <= '0;
            zrun_reg  <= '0;
            start_reg <= '0;
            stop_reg  <= '0;
            hdr_reg   <= '0;
            seen_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            zrun_reg  <= zrun_next;
            start_reg <= start_next;
            stop_reg  <= stop_next;
            hdr_reg   <= hdr_next;
            seen_reg  <= seen_next;
        end
    end

    // Unit limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_write_enable)
            limit_reg <= cfg_write_data;
    end

    h264ns_result_fifo u_result_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room_for_two (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

    // Skipped bytes before the stream end produce nothing
    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_SKIP |-> push.count == 2'd0)
        else $error("result while skipping");

    // Two results only from a start code on the last byte
    a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> last && push.first.kind == KIND_UNIT
            && push.second.error_code == ERR_EMPTY_UNIT)
        else $error("unexpected result pair");

    // A live stream always reports on its last byte
    a_last_reports: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last && phase_reg != PH_SKIP |-> push.count != 2'd0)
        else $error("stream ended without a result");

    // Stream end returns to the opening with cleared position
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> phase_reg == PH_OPENING && pos_reg == '0 && seen_reg == '0)
        else $error("stream state not cleared");

endmodule

// ===== dv/h264_annex_b_nal_splitter_checker.sv =====
// Checker: predicts NAL unit descriptors and error reports and compares them with the output.
`timescale 1ns / 1ps

module h264_annex_b_nal_splitter_checker
    import h264ns_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_t                   in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_t                  out_data,
    input  logic                  cfg_write_enable,
    input  logic [LIMIT_BITS-1:0] cfg_write_data,
    output int                    mismatch_count,
    output int                    awaiting,
    output int                    results_checked
);

    // Predicted scanner state
    phase_t                  scan_phase;
    logic [OUT_BITS-1:0]     stream_pos;
    logic [1:0]              zero_count;
    logic [OUT_BITS-1:0]     nal_start;
    logic [OUT_BITS-1:0]     nal_stop;
    logic [BYTE_BITS-1:0]    nal_header;
    logic [LIMIT_BITS-1:0]   units_taken;
    logic [LIMIT_BITS-1:0]   limit_reg;

    // Results of the byte being predicted, and results still owed by the block
    out_t step_results[$];
    out_t pending_results[$];

    function automatic logic [OUT_BITS-1:0] next_pos(input logic [OUT_BITS-1:0] p);
        return (p == '1) ? p : p + 1'b1;
    endfunction

    function automatic void restart_stream();
        scan_phase  = PH_OPENING;
        stream_pos  = '0;
        zero_count  = '0;
        nal_start   = '0;
        nal_stop    = '0;
        nal_header  = '0;
        units_taken = '0;
    endfunction

    function automatic void add_result(input logic kind, input logic [OUT_BITS-1:0] off,
                                       input logic [OUT_BITS-1:0] len,
                                       input logic [BYTE_BITS-1:0] hdr,
                                       input err_code_t code, input logic done);
        out_t r;
        r.kind        = kind;
        r.unit_offset = off;
        r.unit_length = len;
        r.unit_type   = hdr[4:0];
        r.ref_idc     = hdr[6:5];
        r.error_code  = code;
        r.stream_done = done;
        r.last_in_run = 1'b0;
        step_results.insert(step_results.size(), r);
    endfunction

    function automatic void report_error(input logic [OUT_BITS-1:0] off, input err_code_t code);
        add_result(KIND_ERROR, off, '0, '0, code, 1'b1);
    endfunction

    // Close the current unit; returns 1 when the unit raised an error
    function automatic bit close_nal(input logic done);
        if (nal_stop <= nal_start)
        begin
            report_error(nal_start, ERR_EMPTY_UNIT);
            return 1'b1;
        end
        if (nal_header[7])
        begin
            report_error(nal_start, ERR_FORBIDDEN);
            return 1'b1;
        end
        if (units_taken >= limit_reg)
        begin
            report_error(nal_start, ERR_TOO_MANY);
            return 1'b1;
        end
        add_result(KIND_UNIT, nal_start, nal_stop - nal_start, nal_header, ERR_NONE, done);
        if (units_taken != SEEN_MAX)
            units_taken = units_taken + 1'b1;
        return 1'b0;
    endfunction

    // Work out the results of one accepted byte and queue them
    function automatic void predict_byte(input in_t item);
        logic [OUT_BITS-1:0]  p;
        logic [BYTE_BITS-1:0] b;
        logic                 last;
        bit                   halt;
        out_t                 r;
        p    = stream_pos;
        b    = item.byte_value;
        last = item.stream_last;
        halt = 1'b0;
        step_results.delete();
        case (scan_phase)
            PH_SKIP:
            begin
                // drop bytes until the stream ends
            end
            PH_BODY:
            begin
                if (p == nal_start)
                    nal_header = b;
                if (b == START_BYTE && zero_count >= ZRUN_MAX)
                begin
                    halt = close_nal(1'b0);
                    if (!halt)
                    begin
                        nal_start  = next_pos(p);
                        nal_stop   = nal_start;
                        zero_count = '0;
                        // start code on the final byte leaves an empty unit
                        if (last)
                        begin
                            report_error(nal_start, ERR_EMPTY_UNIT);
                            halt = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (b == ZERO_BYTE)
                    begin
                        if (zero_count < ZRUN_MAX)
                            zero_count = zero_count + 2'd1;
                    end
                    else
                    begin
                        zero_count = '0;
                        nal_stop   = next_pos(p);
                    end
                    if (last)
                        halt = close_nal(1'b1);
                end
            end
            default:
            begin
                if (b == ZERO_BYTE)
                begin
                    if (zero_count < ZRUN_MAX)
                        zero_count = zero_count + 2'd1;
                    if (last)
                    begin
                        report_error('0, ERR_NO_UNIT);
                        halt = 1'b1;
                    end
                end
                else if (zero_count < ZRUN_MAX || b != START_BYTE)
                begin
                    report_error(p, ERR_BAD_OPENING);
                    halt = 1'b1;
                end
                else
                begin
                    nal_start  = next_pos(p);
                    nal_stop   = nal_start;
                    zero_count = '0;
                    scan_phase = PH_BODY;
                    if (last)
                    begin
                        report_error(nal_start, ERR_EMPTY_UNIT);
                        halt = 1'b1;
                    end
                end
            end
        endcase
        stream_pos = next_pos(p);
        if (halt)
            scan_phase = PH_SKIP;
        if (last)
            restart_stream();
        for (int i = 0; i < step_results.size(); i++)
        begin
            r = step_results[i];
            r.last_in_run = (i == step_results.size() - 1);
            pending_results.insert(pending_results.size(), r);
        end
    endfunction

    function automatic string describe(input out_t r);
        return $sformatf("kind=%0d off=%0d len=%0d type=%0d ref=%0d err=%0d done=%0d last=%0d",
                         r.kind, r.unit_offset, r.unit_length, r.unit_type, r.ref_idc,
                         r.error_code, r.stream_done, r.last_in_run);
    endfunction

    // Watch both channels and the config port at every edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        out_t want;
        if (!rst_n)
        begin
            restart_stream();
            limit_reg = LIMIT_RESET;
            pending_results.delete();
            mismatch_count  = 0;
            awaiting        = 0;
            results_checked = 0;
        end
        else
        begin
            if (cfg_write_enable)
                limit_reg = cfg_write_data;
            if (in_valid && in_ready)
                predict_byte(in_data);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] unexpected result: %s", $realtime, describe(out_data));
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (out_data.kind        !== want.kind        ||
                        out_data.unit_offset !== want.unit_offset ||
                        out_data.unit_length !== want.unit_length ||
                        out_data.unit_type   !== want.unit_type   ||
                        out_data.ref_idc     !== want.ref_idc     ||
                        out_data.error_code  !== want.error_code  ||
                        out_data.stream_done !== want.stream_done ||
                        out_data.last_in_run !== want.last_in_run)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("[%0t] mismatch on result %0d", $realtime, results_checked);
                            $display("    expected %s", describe(want));
                            $display("    actual   %s", describe(out_data));
                        end
                    end
                end
            end
            awaiting = pending_results.size();
        end
    end

endmodule

// ===== dv/h264_annex_b_nal_splitter_top_tb.sv =====
// Testbench top: stream stimulus, flow control and verdict for the NAL unit splitter.
`timescale 1ns / 1ps

module h264_annex_b_nal_splitter_top_tb;
    import h264ns_pkg::*;

    localparam int PHASE_BYTES  = 325;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_t                   in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_t                  out_data;
    logic                  cfg_write_enable;
    logic [LIMIT_BITS-1:0] cfg_write_data;

    int mismatch_count;
    int awaiting;
    int results_checked;

    // Flow control knobs; holds_done is written by the receiver, the rest by the stimulus
    int idle_pct;
    int stall_pct;
    int hold_requests;
    int holds_done;

    int bytes_sent;
    int streams_sent;
    int limits_used;
    logic [BYTE_BITS-1:0] stream_bytes[$];

    h264_annex_b_nal_splitter_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_data         (out_data),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data)
    );

    h264_annex_b_nal_splitter_checker nal_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_data         (out_data),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .mismatch_count   (mismatch_count),
        .awaiting         (awaiting),
        .results_checked  (results_checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Payload byte biased toward zeros and start bytes
    function automatic logic [BYTE_BITS-1:0] rand_payload();
        case ($urandom_range(7))
            0, 1:    return ZERO_BYTE;
            2:       return START_BYTE;
            default: return BYTE_BITS'($urandom_range(255));
        endcase
    endfunction

    // Append one byte to the stream under construction
    function automatic void add_byte(input logic [BYTE_BITS-1:0] value);
        stream_bytes.insert(stream_bytes.size(), value);
    endfunction

    // Load up to eight bytes, most significant first
    function automatic void queue_bytes(input logic [63:0] packed_bytes, input int count);
        stream_bytes.delete();
        for (int i = count - 1; i >= 0; i--)
            add_byte(packed_bytes[i*8 +: 8]);
    endfunction

    // Mostly well-formed streams with random content; the rest broken or noise
    function automatic void build_random_stream();
        int              sel;
        int              nunits;
        int              plen;
        logic [BYTE_BITS-1:0] hdr;
        stream_bytes.delete();
        sel = $urandom_range(99);
        if (sel < 80)
        begin
            repeat ($urandom_range(4, 2)) add_byte(ZERO_BYTE);
            add_byte(START_BYTE);
            nunits = $urandom_range(4, 1);
            for (int u = 0; u < nunits; u++)
            begin
                hdr = BYTE_BITS'($urandom_range(255));
                if ($urandom_range(7) != 0)
                    hdr[7] = 1'b0;
                // occasional unit made of zeros only
                if ($urandom_range(15) == 0)
                    hdr = ZERO_BYTE;
                add_byte(hdr);
                plen = (hdr == ZERO_BYTE) ? 0 : $urandom_range(6);
                repeat (plen) add_byte(rand_payload());
                if (u != nunits - 1 || $urandom_range(9) == 0)
                begin
                    if ($urandom_range(3) == 0)
                        add_byte(ZERO_BYTE);
                    add_byte(ZERO_BYTE);
                    add_byte(ZERO_BYTE);
                    add_byte(START_BYTE);
                end
                else
                begin
                    repeat ($urandom_range(2)) add_byte(ZERO_BYTE);
                end
            end
        end
        else if (sel < 88)
        begin
            repeat ($urandom_range(3)) add_byte(ZERO_BYTE);
            add_byte(BYTE_BITS'($urandom_range(255, 1)));
            repeat ($urandom_range(3)) add_byte(rand_payload());
        end
        else if (sel < 94)
        begin
            repeat ($urandom_range(5, 1)) add_byte(ZERO_BYTE);
        end
        else
        begin
            repeat ($urandom_range(8, 1)) add_byte(rand_payload());
        end
    endfunction

    // One input transaction; valid stays up across back-to-back bytes
    task automatic send_byte(input logic [BYTE_BITS-1:0] value, input logic last);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {value, last};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_bytes.size(); i++)
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
        streams_sent++;
    endtask

    // Stop sending and wait until every predicted result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (awaiting == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        limits_used++;
    endtask

    // Receiver: random stalls, plus one long hold-off when requested
    initial
    begin
        out_ready  <= 1'b0;
        holds_done = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                holds_done++;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [LIMIT_BITS-1:0] phase_limit [4];
        int                    phase_idle  [4];
        int                    phase_stall [4];
        int                    start_count;
        bit                    paused;
        phase_limit = '{16'd2, 16'd1, 16'hFFFF, 16'd3};
        phase_idle  = '{0, 65, 0, 14};
        phase_stall = '{0, 0, 65, 14};
        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        in_data          <= '0;
        cfg_write_enable <= 1'b0;
        cfg_write_data   <= '0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_requests = 0;
        bytes_sent    = 0;
        streams_sent  = 0;
        limits_used   = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed streams at the reset limit
        queue_bytes(64'h0000, 2);                 // zeros only
        send_stream();
        queue_bytes(64'h000507, 3);               // bad opening byte
        send_stream();
        queue_bytes(64'h01, 1);                   // start byte with no zeros ahead
        send_stream();
        queue_bytes(64'h00000125FF000001, 8);     // descriptor, then start code on last byte
        send_stream();
        queue_bytes(64'h0000019F00, 5);           // forbidden bit in header
        send_stream();
        queue_bytes(64'h00000100000144, 7);       // empty unit mid-stream
        send_stream();

        // Random phases, each under its own limit and flow-control mix
        for (int ph = 0; ph < 4; ph++)
        begin
            drain_results();
            write_limit(phase_limit[ph]);
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            if (ph == 2)
                hold_requests++;
            start_count = bytes_sent;
            paused      = 1'b0;
            while (bytes_sent - start_count < PHASE_BYTES)
            begin
                if (ph == 3 && !paused && bytes_sent - start_count >= PHASE_BYTES / 2)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                build_random_stream();
                send_stream();
            end
        end

        drain_results();
        $display("Sent %0d bytes in %0d streams under %0d unit limits; %0d results checked.",
                 bytes_sent, streams_sent, limits_used, results_checked);
        if (mismatch_count == 0 && awaiting == 0)
            $display("h264_annex_b_nal_splitter_top test passed");
        else
            $display("h264_annex_b_nal_splitter_top test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("Timeout with %0d results outstanding", awaiting);
        $display("h264_annex_b_nal_splitter_top test failed");
        $finish;
    end

endmodule
